[sv/rscc_pkg.sv]
`default_nettype none
package rscc_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int MAX_FRAME  = 1536;

	localparam int TAIL_W = 6;
	localparam int LEN_W  = 11;
	localparam int CAP_W  = 16;
	localparam int CRC_W  = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd2048;
	localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB8_8320;

	typedef enum logic {
		MODE_HEADER = 1'b0,
		MODE_DATA   = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_BYTE   = 2'd0,
		ST_GOOD   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [TAIL_W-1:0] ring_head;
		logic [31:0]       slot_len;
		logic [31:0]       slot_crc;
		logic [7:0]        data_byte;
	} rscc_item_t;

	typedef struct packed {
		logic              emit;
		logic [1:0]        status;
		logic [7:0]        out_byte;
		logic              byte_valid;
		logic [LEN_W-1:0]  frame_length;
		logic [TAIL_W-1:0] next_tail;
		logic              last;
	} rscc_result_t;

endpackage
`default_nettype wire

[sv/rscc_crc_byte.sv]
`default_nettype none
module rscc_crc_byte
	import rscc_pkg::*;
(
	input  wire logic [CRC_W-1:0] crc_in,
	input  wire logic [7:0]       data,
	output logic      [CRC_W-1:0] crc_out
);

	// Reflected CRC-32, one bit per step, eight steps per byte.
	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-8){1'b0}}, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

[sv/rscc_slot_ctl.sv]
`default_nettype none
module rscc_slot_ctl
	import rscc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CAP_W-1:0] capacity,
	input  wire logic             fire,
	input  wire rscc_item_t       item,
	output rscc_result_t          res
);

	logic [TAIL_W-1:0] tail_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  exp_crc_q;
	logic [LEN_W-1:0]  left_q;
	logic [LEN_W-1:0]  acc_len_q;
	logic              active_q;

	logic [CRC_W-1:0]  crc_next;
	logic [TAIL_W-1:0] tail_inc;
	logic [TAIL_W-1:0] head;
	logic              len_bad;
	logic [LEN_W-1:0]  left_dec;

	logic [TAIL_W-1:0] tail_d;
	logic [CRC_W-1:0]  crc_d;
	logic [CRC_W-1:0]  exp_crc_d;
	logic [LEN_W-1:0]  left_d;
	logic [LEN_W-1:0]  acc_len_d;
	logic              active_d;

	rscc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (item.data_byte),
		.crc_out (crc_next)
	);

	assign head     = item.ring_head & TAIL_W'(SLOT_COUNT - 1);
	assign tail_inc = (tail_q == TAIL_W'(SLOT_COUNT - 1)) ? '0 : tail_q + 1'b1;
	assign len_bad  = (item.slot_len == '0)
		|| (item.slot_len > {{(32-CAP_W){1'b0}}, capacity})
		|| (item.slot_len > 32'(MAX_FRAME));
	assign left_dec = left_q - 1'b1;

	always_comb begin
		tail_d    = tail_q;
		crc_d     = crc_q;
		exp_crc_d = exp_crc_q;
		left_d    = left_q;
		acc_len_d = acc_len_q;
		active_d  = active_q;
		res       = '0;
		res.next_tail = tail_q;
		if (item.mode == MODE_HEADER) begin
			active_d = 1'b0;
			left_d   = '0;
			if (head == tail_q) begin
				res.emit   = 1'b1;
				res.status = ST_EMPTY;
			end else if (len_bad) begin
				tail_d        = tail_inc;
				res.emit      = 1'b1;
				res.status    = ST_REJECT;
				res.next_tail = tail_inc;
				res.last      = 1'b1;
			end else begin
				active_d  = 1'b1;
				left_d    = item.slot_len[LEN_W-1:0];
				acc_len_d = item.slot_len[LEN_W-1:0];
				exp_crc_d = item.slot_crc;
				crc_d     = CRC_INIT;
			end
		end else if (active_q) begin
			crc_d          = crc_next;
			left_d         = left_dec;
			res.emit       = 1'b1;
			res.out_byte   = item.data_byte;
			res.byte_valid = 1'b1;
			if (left_dec != '0) begin
				res.status = ST_BYTE;
			end else begin
				active_d      = 1'b0;
				tail_d        = tail_inc;
				res.next_tail = tail_inc;
				res.last      = 1'b1;
				if (~crc_next == exp_crc_q) begin
					res.status       = ST_GOOD;
					res.frame_length = acc_len_q;
				end else begin
					res.status = ST_REJECT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q    <= '0;
			crc_q     <= CRC_INIT;
			exp_crc_q <= '0;
			left_q    <= '0;
			acc_len_q <= '0;
			active_q  <= 1'b0;
		end else if (fire) begin
			tail_q    <= tail_d;
			crc_q     <= crc_d;
			exp_crc_q <= exp_crc_d;
			left_q    <= left_d;
			acc_len_q <= acc_len_d;
			active_q  <= active_d;
		end
	end

endmodule
`default_nettype wire

[sv/ring_slot_consumer_crc_check.sv]
// Ring slot consumer with CRC-32 check.
// Input channel (in_valid/in_ready) carries one transaction per item: a slot
// header (mode 0: ring_head, slot_len, slot_crc) or one payload byte (mode 1:
// data_byte). Output channel (out_valid/out_ready) carries status, out_byte,
// byte_valid, frame_length, next_tail and last.
// Each input transaction lands in an input register; the slot controller
// then evaluates it against the ring state (tail, running CRC, bytes left)
// and loads the result register. A result thus passes through the input
// register and the result register before it shows on the output.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the combinational byte-wide CRC update between the registers.
// Items that yield no result (good header, stray data byte) are retired
// without touching the output register.
// cfg_we/cfg_wdata write buffer_capacity; write it only when idle.
// Reset clears tail, frame state, both valids; presets CRC; capacity is 2048.
// When the receiver stalls, the result register holds and the input register
// holds its item; in_ready drops only once both are full.
`default_nettype none
module ring_slot_consumer_crc_check
	import rscc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              mode,
	input  wire logic [TAIL_W-1:0] ring_head,
	input  wire logic [31:0]       slot_len,
	input  wire logic [31:0]       slot_crc,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic [LEN_W-1:0]       frame_length,
	output logic [TAIL_W-1:0]      next_tail,
	output logic                   last
);

	logic [CAP_W-1:0] capacity_q;
	logic             valid_s1;
	rscc_item_t       item_s1;
	logic             out_valid_q;
	rscc_result_t     res_q;
	rscc_result_t     res;
	logic             fire;

	// Process the held item once the result register is free or draining.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Input register: capture each transaction, drop valid once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mode      <= mode;
			item_s1.ring_head <= ring_head;
			item_s1.slot_len  <= slot_len;
			item_s1.slot_crc  <= slot_crc;
			item_s1.data_byte <= data_byte;
		end
	end

	rscc_slot_ctl u_slot_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.fire     (fire),
		.item     (item_s1),
		.res      (res)
	);

	// Result register: load on an emitting item, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign out_byte     = res_q.out_byte;
	assign byte_valid   = res_q.byte_valid;
	assign frame_length = res_q.frame_length;
	assign next_tail    = res_q.next_tail;
	assign last         = res_q.last;

endmodule
`default_nettype wire

[sv/rscc_checker.sv]
`default_nettype none
module rscc_checker
	import rscc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [1:0]        status,
	input wire logic [7:0]        out_byte,
	input wire logic              byte_valid,
	input wire logic [LEN_W-1:0]  frame_length,
	input wire logic              last
);

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
			&& $stable(frame_length) && $stable(last))
		else $error("stalled result changed");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == '0)
		else $error("out_byte set without byte_valid");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BYTE |-> byte_valid && !last && frame_length == '0)
		else $error("forwarded byte result malformed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> !last && !byte_valid && frame_length == '0)
		else $error("empty ring result malformed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_length != '0 |-> status == ST_GOOD && last && byte_valid)
		else $error("frame length outside good frame end");

endmodule

bind ring_slot_consumer_crc_check rscc_checker u_rscc_checker (.*);
`default_nettype wire

[bench/ring_slot_consumer_crc_check_checker.sv]
module ring_slot_consumer_crc_check_checker
	import rscc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic              mode,
	input  wire logic [TAIL_W-1:0] ring_head,
	input  wire logic [31:0]       slot_len,
	input  wire logic [31:0]       slot_crc,
	input  wire logic [7:0]        data_byte,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [1:0]        status,
	input  wire logic [7:0]        out_byte,
	input  wire logic              byte_valid,
	input  wire logic [LEN_W-1:0]  frame_length,
	input  wire logic [TAIL_W-1:0] next_tail,
	input  wire logic              last,
	output int                     fail_count,
	output int                     pending,
	output int                     checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t           status;
		logic [7:0]        data;
		logic              data_valid;
		logic [LEN_W-1:0]  length;
		logic [TAIL_W-1:0] tail;
		logic              ends_slot;
	} slot_result_t;

	slot_result_t      slot_results_q[$];
	slot_result_t      oldest;
	logic [TAIL_W-1:0] tail_idx;
	logic [CRC_W-1:0]  crc_acc;
	logic [CRC_W-1:0]  crc_want;
	logic [LEN_W-1:0]  bytes_left;
	logic [LEN_W-1:0]  frame_len;
	logic              frame_open;
	logic [CAP_W-1:0]  capacity;
	int                mismatches = 0;
	int                results_seen = 0;
	int                results_waiting = 0;

	assign fail_count = mismatches;
	assign pending    = results_waiting;
	assign checked    = results_seen;

	function automatic logic [CRC_W-1:0] crc32_update(logic [CRC_W-1:0] acc, logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				results_seen, name, got, want));
	endtask

	task automatic advance_tail();
		tail_idx = (tail_idx == TAIL_W'(SLOT_COUNT - 1)) ? '0 : tail_idx + 1'b1;
	endtask

	task automatic queue_result(status_t s, logic [7:0] d, logic dv, logic [LEN_W-1:0] l,
			logic e);
		slot_result_t r;
		r.status     = s;
		r.data       = d;
		r.data_valid = dv;
		r.length     = l;
		r.tail       = tail_idx;
		r.ends_slot  = e;
		slot_results_q.push_back(r);
	endtask

	task automatic predict_slot_item(logic m, logic [TAIL_W-1:0] head, logic [31:0] len,
			logic [31:0] crc, logic [7:0] b);
		if (m == MODE_HEADER) begin
			// a header always drops whatever frame was open
			frame_open = 1'b0;
			bytes_left = '0;
			if (head == tail_idx) begin
				queue_result(ST_EMPTY, 8'd0, 1'b0, '0, 1'b0);
			end else if (len == 0 || len > {16'd0, capacity} || len > MAX_FRAME) begin
				advance_tail();
				queue_result(ST_REJECT, 8'd0, 1'b0, '0, 1'b1);
			end else begin
				frame_open = 1'b1;
				bytes_left = len[LEN_W-1:0];
				frame_len  = len[LEN_W-1:0];
				crc_want   = crc;
				crc_acc    = CRC_INIT;
			end
		end else if (frame_open) begin
			crc_acc    = crc32_update(crc_acc, b);
			bytes_left = bytes_left - 1'b1;
			if (bytes_left != 0) begin
				queue_result(ST_BYTE, b, 1'b1, '0, 1'b0);
			end else begin
				frame_open = 1'b0;
				advance_tail();
				if (~crc_acc == crc_want)
					queue_result(ST_GOOD, b, 1'b1, frame_len, 1'b1);
				else
					queue_result(ST_REJECT, b, 1'b1, '0, 1'b1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_idx   = '0;
			crc_acc    = CRC_INIT;
			crc_want   = '0;
			bytes_left = '0;
			frame_len  = '0;
			frame_open = 1'b0;
			capacity   = CAP_RESET;
			slot_results_q.delete();
			results_waiting <= 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (out_valid && out_ready) begin
				if (slot_results_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result: status %0d byte 0x%0h tail %0d",
						status, out_byte, next_tail));
				end else begin
					oldest = slot_results_q.pop_front();
					check_field("status", status, oldest.status);
					check_field("out_byte", out_byte, oldest.data);
					check_field("byte_valid", byte_valid, oldest.data_valid);
					check_field("frame_length", frame_length, oldest.length);
					check_field("next_tail", next_tail, oldest.tail);
					check_field("last", last, oldest.ends_slot);
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				predict_slot_item(mode, ring_head, slot_len, slot_crc, data_byte);
			results_waiting <= slot_results_q.size();
		end
	end

endmodule

[bench/ring_slot_consumer_crc_check_tb.sv]
module ring_slot_consumer_crc_check_tb
	import rscc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Give up after this many cycles with no transaction on either channel.
	// In a correct run idle stretches come only from sender gaps, receiver
	// stalls, pipeline latency and the settle time around a capacity write.
	localparam int WATCHDOG_LIMIT = 2000;
	// Counted transactions per capacity setting in the random part.
	localparam int PHASE_ITEMS    = 200;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CAP_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              mode;
	logic [TAIL_W-1:0] ring_head;
	logic [31:0]       slot_len;
	logic [31:0]       slot_crc;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [7:0]        out_byte;
	logic              byte_valid;
	logic [LEN_W-1:0]  frame_length;
	logic [TAIL_W-1:0] next_tail;
	logic              last;

	int                fail_count;
	int                pending;
	int                checked;

	// Stimulus-side guesses of the ring position, used only to aim headers
	// at an empty or non-empty ring. Checking never relies on them.
	logic [TAIL_W-1:0] tail_guess = '0;
	bit                frame_open_guess = 1'b0;
	bit                no_idle = 1'b0;
	int                items_sent = 0;
	int                phase_items = 0;
	int                idle_cycles = 0;
	logic [CAP_W-1:0]  random_cap;

	ring_slot_consumer_crc_check dut (.*);

	ring_slot_consumer_crc_check_checker crc_frame_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: count cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, pending results %0d",
				idle_cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: ready in random stretches, broken by random stalls.
	// Stop stalling once the last phase of the run begins.
	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Offer one transaction and hold it until the block takes it. A sender
	// gap drops valid first; otherwise valid stays high into the next item.
	// Stray data bytes pass tally = 0 so they do not count toward a phase.
	task automatic send_item(mode_t m, logic [TAIL_W-1:0] h, logic [31:0] len,
			logic [31:0] crc, logic [7:0] b, bit tally);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		ring_head <= h;
		slot_len  <= len;
		slot_crc  <= crc;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (tally)
			phase_items++;
	endtask

	// Pick a producer head that leaves the ring non-empty.
	function automatic logic [TAIL_W-1:0] busy_head();
		logic [TAIL_W-1:0] h;
		h = TAIL_W'($urandom);
		if (h == tail_guess)
			h = h + 1'b1;
		return h;
	endfunction

	// Length that must be turned away: zero, one past the limit, all ones,
	// or a random 32-bit value above the limit.
	function automatic logic [31:0] bad_length(int maxlen);
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = maxlen + 1;
			2: v = '1;
			default: begin
				v = $urandom;
				if (v <= maxlen)
					v = maxlen + $urandom_range(1, 100);
			end
		endcase
		return v;
	endfunction

	// Header plus payload with random bytes. The slot CRC is the zlib CRC-32
	// of the payload, or that value with one bit flipped. Send only the first
	// cut bytes to leave the frame open for the next header to abort.
	task automatic send_frame(int len, bit crc_ok, int cut);
		logic [7:0]  body [MAX_FRAME];
		logic [31:0] c;
		c = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			body[i] = 8'($urandom);
			c = c ^ {24'd0, body[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		c = ~c;
		if (!crc_ok)
			c = c ^ (32'd1 << $urandom_range(0, 31));
		send_item(MODE_HEADER, busy_head(), len, c, 8'($urandom), 1'b1);
		for (int i = 0; i < cut; i++)
			send_item(MODE_DATA, TAIL_W'($urandom), $urandom, $urandom, body[i], 1'b1);
		if (cut == len) begin
			tail_guess = tail_guess + 1'b1;
			frame_open_guess = 1'b0;
		end else begin
			frame_open_guess = 1'b1;
		end
	endtask

	// Rejected header: the slot is consumed, so the tail moves on.
	task automatic send_bad_header(logic [TAIL_W-1:0] h, logic [31:0] len, logic [31:0] crc);
		send_item(MODE_HEADER, h, len, crc, 8'($urandom), 1'b1);
		tail_guess = tail_guess + 1'b1;
		frame_open_guess = 1'b0;
	endtask

	// Drop valid and hold off until every expected result has come back,
	// then let the pipeline settle for items that produce nothing.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random step: mostly whole frames with random content, then bad
	// lengths, aborted frames, empty-ring headers and stray bytes as noise.
	task automatic random_step(int maxlen);
		int pick;
		int r;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 70 && maxlen > 0) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, maxlen < 16 ? maxlen : 16);
			else if (r < 95)
				len = $urandom_range(1, maxlen < 64 ? maxlen : 64);
			else if (maxlen <= 64)
				len = maxlen;
			else
				len = $urandom_range(65, maxlen < 256 ? maxlen : 256);
			send_frame(len, $urandom_range(0, 3) != 0, len);
		end else if (pick < 82) begin
			send_bad_header(busy_head(), bad_length(maxlen), $urandom);
		end else if (pick < 90 && maxlen > 0) begin
			len = $urandom_range(1, maxlen < 32 ? maxlen : 32);
			send_frame(len, 1'b1, $urandom_range(0, len - 1));
		end else if (pick < 95 || frame_open_guess) begin
			// head equal to the tail: ring empty, and any open frame is dropped
			send_item(MODE_HEADER, tail_guess, $urandom, $urandom, 8'($urandom), 1'b1);
			frame_open_guess = 1'b0;
		end else begin
			repeat ($urandom_range(1, 3))
				send_item(MODE_DATA, TAIL_W'($urandom), $urandom, $urandom,
					8'($urandom), 1'b0);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] cap;
		int               maxlen;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		mode      = MODE_HEADER;
		ring_head = '0;
		slot_len  = '0;
		slot_crc  = '0;
		data_byte = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, capacity still at its reset value.
		// Head equal to tail: ring empty, tail stays.
		send_item(MODE_HEADER, 6'd0, 32'd5, 32'hFFFF_FFFF, 8'h00, 1'b1);
		// Data bytes with no frame open are ignored.
		send_item(MODE_DATA, 6'd63, '1, '1, 8'hFF, 1'b0);
		send_item(MODE_DATA, 6'd0, '0, '0, 8'h00, 1'b0);
		// Zero length, one past the largest frame, and all ones: reject.
		send_bad_header(6'd63, 32'd0, 32'd0);
		send_bad_header(6'd40, MAX_FRAME + 1, 32'hFFFF_FFFF);
		send_bad_header(6'd5, 32'hFFFF_FFFF, 32'd0);
		// One-byte frame, good check; three-byte frame, corrupted check.
		send_frame(1, 1'b1, 1);
		send_frame(3, 1'b0, 3);
		// Open a frame, stop halfway, and let the next header abort it.
		send_frame(4, 1'b1, 2);
		send_frame(2, 1'b1, 2);
		// Another open frame, cut short and aborted by a header on an empty ring.
		send_frame(5, 1'b1, 3);
		send_item(MODE_HEADER, tail_guess, 32'd1, 32'd0, 8'hA5, 1'b1);
		frame_open_guess = 1'b0;
		send_frame(2, 1'b0, 2);

		// Random part: one pass per capacity setting, extremes included.
		// The tail wraps many times over the run.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: cap = 16'hFFFF;
				1: cap = 16'd0;
				2: cap = 16'd1;
				3: cap = 16'd64;
				4: cap = CAP_W'(MAX_FRAME);
				5: begin
					random_cap = CAP_W'($urandom_range(2, 65535));
					cap = random_cap;
				end
				default: cap = CAP_RESET;
			endcase
			// no idling on either side during the last pass
			if (p == 6)
				no_idle = 1'b1;
			write_capacity(cap);
			maxlen = (cap < MAX_FRAME) ? cap : MAX_FRAME;
			phase_items = 0;
			// a header of the largest length the block takes, left open for
			// the next header to abort
			if (p == 0)
				send_frame(MAX_FRAME, 1'b1, 8);
			while (phase_items < PHASE_ITEMS)
				random_step(maxlen);
		end

		drain();
		repeat (8) @(posedge clk);

		$display("run: %0d input transactions, %0d results checked, tail ended at %0d",
			items_sent, checked, tail_guess);
		$display("run: capacity 2048, 65535, 0, 1, 64, 1536, %0d, 2048; full and aborted %s",
			random_cap, "frames, bad lengths, empty ring, stray bytes");
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
